// File: sv/mrta_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_pkg
// Shared types and constants of the R-type ALU execute block: operation codes,
// the input and result beat layouts and the register file write control.
// ----------------------------------------------------------------------------
package mrta_pkg;

    localparam int REG_COUNT_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W   = 5;
    localparam int IDX_W  = 5;
    localparam int SHA_W  = 5;
    localparam int LOAD_W = 32;
    localparam int RES_W  = 32;

    localparam logic [OP_W-1:0] OP_ADD   = 5'd0;
    localparam logic [OP_W-1:0] OP_ADDU  = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB   = 5'd2;
    localparam logic [OP_W-1:0] OP_SUBU  = 5'd3;
    localparam logic [OP_W-1:0] OP_AND   = 5'd4;
    localparam logic [OP_W-1:0] OP_OR    = 5'd5;
    localparam logic [OP_W-1:0] OP_NOR   = 5'd6;
    localparam logic [OP_W-1:0] OP_XOR   = 5'd7;
    localparam logic [OP_W-1:0] OP_SLL   = 5'd8;
    localparam logic [OP_W-1:0] OP_SRL   = 5'd9;
    localparam logic [OP_W-1:0] OP_SRA   = 5'd10;
    localparam logic [OP_W-1:0] OP_SLLV  = 5'd11;
    localparam logic [OP_W-1:0] OP_SRLV  = 5'd12;
    localparam logic [OP_W-1:0] OP_SRAV  = 5'd13;
    localparam logic [OP_W-1:0] OP_SLT   = 5'd14;
    localparam logic [OP_W-1:0] OP_SLTU  = 5'd15;
    localparam logic [OP_W-1:0] OP_WRITE = 5'd16;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [IDX_W-1:0]  src_a_index;
        logic [IDX_W-1:0]  src_b_index;
        logic [IDX_W-1:0]  dest_index;
        logic [SHA_W-1:0]  shift_amount;
        logic [LOAD_W-1:0] load_value;
    } t_in_beat;

    typedef struct packed {
        logic [RES_W-1:0] result_value;
        logic [IDX_W-1:0] result_dest;
    } t_out_beat;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } t_wr_ctl;

endpackage
`default_nettype wire

// File: sv/mips_register_type_alu_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_register_type_alu_execute
// MIPS32 R-type ALU execute stage over a register file, with a preload op.
// ----------------------------------------------------------------------------
// The block takes one instruction beat per cycle unless a waiting result beat
// stalls it; a beat goes via the execute stage to the output register. The
// register file memory is read when a beat is accepted and written when that
// beat leaves the execute stage; a write landing on the same edge as a read is
// forwarded, so dependent instructions issue back to back. Entries read as
// zero right after reset without any clearing pass. Register zero and numbers
// beyond the file read as zero and ignore writes, and an undefined op writes
// nothing and returns zero value and destination.
module mips_register_type_alu_execute #(
    parameter int REG_COUNT  = mrta_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = mrta_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire mrta_pkg::t_in_beat  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output mrta_pkg::t_out_beat      o_out_data
);
    import mrta_pkg::*;

    logic                  in_acc;
    logic                  s1_adv;

    logic                  r_s1_valid;
    logic [OP_W-1:0]       r_s1_op;
    logic [IDX_W-1:0]      r_s1_dest;
    logic [SHA_W-1:0]      r_s1_shamt;
    logic [LOAD_W-1:0]     r_s1_load;

    logic                  r_out_valid;
    t_out_beat             r_out;
    t_out_beat             n_out;

    logic [DATA_WIDTH-1:0] op_a;
    logic [DATA_WIDTH-1:0] op_b;
    logic [DATA_WIDTH-1:0] alu_result;
    logic                  alu_ok;
    t_wr_ctl               wr;

    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in_valid && o_in_ready;

    assign wr.en  = s1_adv && alu_ok;
    assign wr.idx = r_s1_dest;

    mrta_regfile #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_acc),
        .i_rd_a_idx  (i_in_data.src_a_index),
        .i_rd_b_idx  (i_in_data.src_b_index),
        .o_rd_a_data (op_a),
        .o_rd_b_data (op_b),
        .i_wr        (wr),
        .i_wr_data   (alu_result)
    );

    mrta_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .i_op     (r_s1_op),
        .i_a      (op_a),
        .i_b      (op_b),
        .i_shamt  (r_s1_shamt),
        .i_load   (r_s1_load),
        .o_result (alu_result),
        .o_ok     (alu_ok)
    );

    always_comb begin
        if (alu_ok) begin
            n_out.result_value = RES_W'(alu_result);
            n_out.result_dest  = r_s1_dest;
        end else begin
            n_out.result_value = '0;
            n_out.result_dest  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_in_data.op;
            r_s1_dest  <= i_in_data.dest_index;
            r_s1_shamt <= i_in_data.shift_amount;
            r_s1_load  <= i_in_data.load_value;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_write_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_s1_valid && s1_adv))
        else $error("Register file written without an advancing beat.");

    a_accept_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("Accepted beat did not reach the execute stage.");

    a_ready_low_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_out_valid && !i_out_ready))
        else $error("Input stalled while the pipeline could move.");

    a_no_advance_into_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !s1_adv)
        else $error("Execute stage overwrote a waiting result beat.");
`endif

endmodule
`default_nettype wire

// File: sv/mrta_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_alu
// Combinational R-type operation unit: add, subtract, logic, shifts, set on
// less than and the register preload. Flags codes that define no operation.
// ----------------------------------------------------------------------------
module mrta_alu #(
    parameter int DATA_WIDTH = mrta_pkg::DATA_WIDTH_DEF
) (
    input  wire logic [mrta_pkg::OP_W-1:0]   i_op,
    input  wire logic [DATA_WIDTH-1:0]       i_a,
    input  wire logic [DATA_WIDTH-1:0]       i_b,
    input  wire logic [mrta_pkg::SHA_W-1:0]  i_shamt,
    input  wire logic [mrta_pkg::LOAD_W-1:0] i_load,
    output logic      [DATA_WIDTH-1:0]       o_result,
    output logic                             o_ok
);
    import mrta_pkg::*;

    logic [SHA_W-1:0] vcount;

    assign vcount = i_a[SHA_W-1:0];

    always_comb begin
        o_result = '0;
        o_ok     = 1'b1;
        unique case (i_op)
            OP_ADD, OP_ADDU: o_result = i_a + i_b;
            OP_SUB, OP_SUBU: o_result = i_a - i_b;
            OP_AND:   o_result = i_a & i_b;
            OP_OR:    o_result = i_a | i_b;
            OP_NOR:   o_result = ~(i_a | i_b);
            OP_XOR:   o_result = i_a ^ i_b;
            OP_SLL:   o_result = i_b << i_shamt;
            OP_SRL:   o_result = i_b >> i_shamt;
            OP_SRA:   o_result = $signed(i_b) >>> i_shamt;
            OP_SLLV:  o_result = i_b << vcount;
            OP_SRLV:  o_result = i_b >> vcount;
            OP_SRAV:  o_result = $signed(i_b) >>> vcount;
            OP_SLT:   o_result = {{(DATA_WIDTH-1){1'b0}}, ($signed(i_a) < $signed(i_b))};
            OP_SLTU:  o_result = {{(DATA_WIDTH-1){1'b0}}, (i_a < i_b)};
            OP_WRITE: o_result = DATA_WIDTH'(i_load);
            default: begin
                o_result = '0;
                o_ok     = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: sv/mrta_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mrta_regfile
// Register file in a synchronous memory with two registered read ports and one
// write port. Per-entry valid bits make unwritten entries read as zero after
// reset, and the last write is forwarded to a read issued at the same edge.
// ----------------------------------------------------------------------------
module mrta_regfile #(
    parameter int REG_COUNT  = mrta_pkg::REG_COUNT_DEF,
    parameter int DATA_WIDTH = mrta_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_rd_en,
    input  wire logic [mrta_pkg::IDX_W-1:0]  i_rd_a_idx,
    input  wire logic [mrta_pkg::IDX_W-1:0]  i_rd_b_idx,
    output logic      [DATA_WIDTH-1:0]       o_rd_a_data,
    output logic      [DATA_WIDTH-1:0]       o_rd_b_data,
    input  wire mrta_pkg::t_wr_ctl           i_wr,
    input  wire logic [DATA_WIDTH-1:0]       i_wr_data
);
    import mrta_pkg::*;

    localparam int AW = $clog2(REG_COUNT);

    logic [DATA_WIDTH-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  r_vld;

    logic [DATA_WIDTH-1:0] r_a_raw;
    logic [DATA_WIDTH-1:0] r_b_raw;
    logic                  r_a_ok;
    logic                  r_b_ok;
    logic [IDX_W-1:0]      r_a_idx;
    logic [IDX_W-1:0]      r_b_idx;

    logic                  r_fwd_en;
    logic [IDX_W-1:0]      r_fwd_idx;
    logic [DATA_WIDTH-1:0] r_fwd_data;

    logic                  we;
    logic                  a_in_range;
    logic                  b_in_range;
    logic [AW-1:0]         a_addr;
    logic [AW-1:0]         b_addr;
    logic [AW-1:0]         w_addr;

    assign we = i_wr.en && (i_wr.idx != '0) && (32'(i_wr.idx) < REG_COUNT);
    assign a_in_range = (i_rd_a_idx != '0) && (32'(i_rd_a_idx) < REG_COUNT);
    assign b_in_range = (i_rd_b_idx != '0) && (32'(i_rd_b_idx) < REG_COUNT);
    assign a_addr = AW'(i_rd_a_idx);
    assign b_addr = AW'(i_rd_b_idx);
    assign w_addr = AW'(i_wr.idx);

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[w_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_a_raw <= r_mem[a_addr];
            r_b_raw <= r_mem[b_addr];
            r_a_idx <= i_rd_a_idx;
            r_b_idx <= i_rd_b_idx;
        end
        if (we) begin
            r_fwd_idx  <= i_wr.idx;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_a_ok   <= 1'b0;
            r_b_ok   <= 1'b0;
            r_fwd_en <= 1'b0;
        end else begin
            if (we) begin
                r_vld[w_addr] <= 1'b1;
                r_fwd_en      <= 1'b1;
            end
            if (i_rd_en) begin
                r_a_ok <= a_in_range && r_vld[a_addr];
                r_b_ok <= b_in_range && r_vld[b_addr];
            end
        end
    end

    // The forwarded write is the latest one, so it wins over the memory word.
    always_comb begin
        priority if (r_fwd_en && (r_fwd_idx == r_a_idx)) begin
            o_rd_a_data = r_fwd_data;
        end else if (r_a_ok) begin
            o_rd_a_data = r_a_raw;
        end else begin
            o_rd_a_data = '0;
        end
        priority if (r_fwd_en && (r_fwd_idx == r_b_idx)) begin
            o_rd_b_data = r_fwd_data;
        end else if (r_b_ok) begin
            o_rd_b_data = r_b_raw;
        end else begin
            o_rd_b_data = '0;
        end
    end

endmodule
`default_nettype wire
